FILE: rtl/suspend_resume_autosave_controller_assert.svh
// Assertion macros used by the lifecycle controller port checker
`ifndef SUSPEND_RESUME_AUTOSAVE_CONTROLLER_ASSERT_SVH
`define SUSPEND_RESUME_AUTOSAVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, clocked on clock, masked during reset
`define SRAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, masked during reset
`define SRAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/srac_pkg.sv
// Types, constants and microprogram for the lifecycle controller
package srac_pkg;

   // Smallest autosave period the register holds, in microseconds
   localparam logic [31:0] MIN_PERIOD_US = 32'd1000000;

   // Register byte address of the autosave period
   localparam logic [2:0] CSR_PERIOD_ADDR = 3'd0;

   // Opcodes of an input item
   localparam logic [3:0] OP_SUSPEND   = 4'd0;
   localparam logic [3:0] OP_SLEEP     = 4'd1;
   localparam logic [3:0] OP_RESTORE   = 4'd2;
   localparam logic [3:0] OP_WAKE      = 4'd3;
   localparam logic [3:0] OP_EXIT      = 4'd4;
   localparam logic [3:0] OP_TICK      = 4'd5;
   localparam logic [3:0] OP_RESET     = 4'd6;
   localparam logic [3:0] OP_CRIT_BEGIN = 4'd7;
   localparam logic [3:0] OP_CRIT_END  = 4'd8;

   typedef enum logic [1:0] {
      MODE_RUNNING,
      MODE_SUSPENDED,
      MODE_EXIT_PENDING
   } mode_type;

   // Microprogram step addresses
   typedef enum logic [3:0] {
      ST_FETCH,
      ST_SUSPEND,
      ST_RESUME,
      ST_EXIT,
      ST_TICK_CHECK,
      ST_ADVANCE,
      ST_RELEASE,
      ST_RESET,
      ST_CRIT_BEGIN,
      ST_CRIT_END,
      ST_EMIT
   } step_type;

   // Datapath action of a step
   typedef enum logic [3:0] {
      ACT_FETCH,
      ACT_SUSPEND,
      ACT_RESUME,
      ACT_EXIT,
      ACT_TICK_CHECK,
      ACT_ADVANCE,
      ACT_RELEASE,
      ACT_RESET,
      ACT_CRIT_BEGIN,
      ACT_CRIT_END,
      ACT_EMIT
   } act_type;

   // Jump condition of a step
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_DISPATCH,
      COND_NOT_DUE,
      COND_DONE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_word_type;

   // Request flags of one result item
   typedef struct packed {
      logic emu_halt;
      logic snd_halt;
      logic snd_restart;
      logic save_now;
      logic quit_now;
   } flags_type;

   // Control store: one word per step
   function automatic ctrl_word_type micro_rom(input step_type s);
      ctrl_word_type w;
      w = '{ACT_EMIT, COND_OUT_FREE, ST_FETCH, ST_EMIT};
      case (s)
         ST_FETCH:      w = '{ACT_FETCH,      COND_DISPATCH, ST_FETCH,   ST_FETCH};
         ST_SUSPEND:    w = '{ACT_SUSPEND,    COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_RESUME:     w = '{ACT_RESUME,     COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_EXIT:       w = '{ACT_EXIT,       COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_TICK_CHECK: w = '{ACT_TICK_CHECK, COND_NOT_DUE,  ST_RELEASE, ST_ADVANCE};
         ST_ADVANCE:    w = '{ACT_ADVANCE,    COND_DONE,     ST_RELEASE, ST_ADVANCE};
         ST_RELEASE:    w = '{ACT_RELEASE,    COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_RESET:      w = '{ACT_RESET,      COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_CRIT_BEGIN: w = '{ACT_CRIT_BEGIN, COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_CRIT_END:   w = '{ACT_CRIT_END,   COND_ALWAYS,   ST_EMIT,    ST_EMIT};
         ST_EMIT:       w = '{ACT_EMIT,       COND_OUT_FREE, ST_FETCH,   ST_EMIT};
         default:       w = '{ACT_EMIT,       COND_OUT_FREE, ST_FETCH,   ST_EMIT};
      endcase
      return w;
   endfunction

   // Dispatch table: first step of each opcode
   function automatic step_type dispatch(input logic [3:0] op);
      step_type s;
      s = ST_EMIT;
      case (op)
         OP_SUSPEND, OP_SLEEP: s = ST_SUSPEND;
         OP_RESTORE, OP_WAKE:  s = ST_RESUME;
         OP_EXIT:              s = ST_EXIT;
         OP_TICK:              s = ST_TICK_CHECK;
         OP_RESET:             s = ST_RESET;
         OP_CRIT_BEGIN:        s = ST_CRIT_BEGIN;
         OP_CRIT_END:          s = ST_CRIT_END;
         default:              s = ST_EMIT;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/suspend_resume_autosave_controller.sv
// Lifecycle controller: microcoded sequencer over mode, deadline and depth state
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_ready     req_opcode, req_now_us
//   rsp       out         rsp_valid / rsp_ready     five request flags
//   csr       in/out      APB, pready tied high     autosave period at 0x0
//
// An item runs fetch, action and emit steps; unknown opcodes skip the action step.
// A tick runs fetch, tick check, k catch-up passes adding one period per cycle,
// release and emit (k = 0 when not due, else floor((now - deadline) / period) + 1).
// The emit step holds while the output register still holds an untaken item;
// the next item is fetched while a result waits. Synchronous reset, no clearing pass.
module suspend_resume_autosave_controller
   import srac_pkg::*;
#(
   parameter int MAX_CRITICAL_DEPTH = 255,
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_opcode,
   input  logic [TIME_BITS-1:0] req_now_us,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_emu_halt,
   output logic                 rsp_snd_halt,
   output logic                 rsp_snd_restart,
   output logic                 rsp_save_now,
   output logic                 rsp_quit_now,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int DEPTH_BITS = $clog2(MAX_CRITICAL_DEPTH + 1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_CRITICAL_DEPTH);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [TIME_BITS-1:0] DEADLINE_RESET = TIME_BITS'(MIN_PERIOD_US);

   step_type                step_ff, step_in;
   mode_type                mode_ff, mode_in;
   logic [TIME_BITS-1:0]    deadline_ff, deadline_in;
   logic [DEPTH_BITS-1:0]   depth_ff, depth_in;
   logic                    save_def_ff, save_def_in;
   logic                    exit_def_ff, exit_def_in;
   logic [31:0]             period_ff, period_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   flags_type               flags_ff, flags_in;
   flags_type               rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   ctrl_word_type           cw;
   logic                    crit;
   logic                    due;
   logic                    out_free;
   logic [TIME_BITS:0]      adv_sum;
   logic                    adv_done;
   logic [TIME_BITS:0]      start_sum;
   logic [TIME_BITS-1:0]    start_deadline;
   logic                    csr_write;

   // Control word of the current step
   assign cw = micro_rom(step_ff);

   // Shared datapath terms
   assign crit     = depth_ff != '0;
   assign due      = (mode_ff == MODE_RUNNING) && (now_ff >= deadline_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Catch-up adder: one period per cycle, saturating at the top of the time range
   assign adv_sum  = {1'b0, deadline_ff} + (TIME_BITS+1)'(period_ff);
   assign adv_done = adv_sum[TIME_BITS] || (adv_sum[TIME_BITS-1:0] > now_ff);

   // Fresh deadline from now, saturating
   assign start_sum      = {1'b0, now_ff} + (TIME_BITS+1)'(period_ff);
   assign start_deadline = start_sum[TIME_BITS] ? TIME_MAX : start_sum[TIME_BITS-1:0];

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_PERIOD_ADDR[2]);
   assign prdata    = (paddr[2] == CSR_PERIOD_ADDR[2]) ? period_ff : 32'd0;

   always_comb begin
      period_in = period_ff;
      if (csr_write) begin
         period_in = (pwdata < MIN_PERIOD_US) ? MIN_PERIOD_US : pwdata;
      end
   end

   // Sequencer: next step from the jump condition
   always_comb begin
      logic taken;
      taken = 1'b0;
      case (cw.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_DISPATCH: taken = req_valid;
         COND_NOT_DUE:  taken = !due;
         COND_DONE:     taken = adv_done;
         COND_OUT_FREE: taken = out_free;
         default:       taken = 1'b1;
      endcase
      if (cw.cond == COND_DISPATCH) begin
         step_in = taken ? dispatch(req_opcode) : cw.on_false;
      end else begin
         step_in = taken ? cw.on_true : cw.on_false;
      end
   end

   // Datapath actions
   always_comb begin
      mode_in      = mode_ff;
      deadline_in  = deadline_ff;
      depth_in     = depth_ff;
      save_def_in  = save_def_ff;
      exit_def_in  = exit_def_ff;
      now_in       = now_ff;
      flags_in     = flags_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (cw.act)
         ACT_FETCH: begin
            req_ready = 1'b1;
            now_in    = req_now_us;
            flags_in  = '0;
         end
         ACT_SUSPEND: begin
            if (mode_ff == MODE_RUNNING) begin
               flags_in.emu_halt = 1'b1;
               flags_in.snd_halt = 1'b1;
               if (crit) save_def_in = 1'b1;
               else flags_in.save_now = 1'b1;
               mode_in = MODE_SUSPENDED;
            end
         end
         ACT_RESUME: begin
            if (mode_ff == MODE_SUSPENDED) begin
               flags_in.snd_restart = 1'b1;
               mode_in     = MODE_RUNNING;
               deadline_in = start_deadline;
            end
         end
         ACT_EXIT: begin
            if (mode_ff != MODE_EXIT_PENDING) begin
               mode_in = MODE_EXIT_PENDING;
               flags_in.emu_halt = 1'b1;
               flags_in.snd_halt = 1'b1;
               if (crit) begin
                  save_def_in = 1'b1;
                  exit_def_in = 1'b1;
               end else begin
                  flags_in.save_now = 1'b1;
                  flags_in.quit_now = 1'b1;
               end
            end
         end
         ACT_TICK_CHECK: begin
            if (due) begin
               if (crit) save_def_in = 1'b1;
               else flags_in.save_now = 1'b1;
            end
         end
         ACT_ADVANCE: begin
            deadline_in = adv_sum[TIME_BITS] ? TIME_MAX : adv_sum[TIME_BITS-1:0];
         end
         ACT_RELEASE: begin
            if (!crit && save_def_ff) begin
               save_def_in = 1'b0;
               flags_in.save_now = 1'b1;
            end
            if (!crit && exit_def_ff) begin
               exit_def_in = 1'b0;
               flags_in.quit_now = 1'b1;
            end
         end
         ACT_RESET: begin
            mode_in     = MODE_RUNNING;
            deadline_in = start_deadline;
            depth_in    = '0;
            save_def_in = 1'b0;
            exit_def_in = 1'b0;
         end
         ACT_CRIT_BEGIN: begin
            if (depth_ff < DEPTH_MAX) depth_in = depth_ff + 1'b1;
         end
         ACT_CRIT_END: begin
            if (crit) depth_in = depth_ff - 1'b1;
         end
         ACT_EMIT: begin
            if (out_free) begin
               rsp_in       = flags_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_FETCH;
         mode_ff      <= MODE_RUNNING;
         deadline_ff  <= DEADLINE_RESET;
         depth_ff     <= '0;
         save_def_ff  <= 1'b0;
         exit_def_ff  <= 1'b0;
         period_ff    <= MIN_PERIOD_US;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         deadline_ff  <= deadline_in;
         depth_ff     <= depth_in;
         save_def_ff  <= save_def_in;
         exit_def_ff  <= exit_def_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      flags_ff <= flags_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_emu_halt    = rsp_ff.emu_halt;
   assign rsp_snd_halt    = rsp_ff.snd_halt;
   assign rsp_snd_restart = rsp_ff.snd_restart;
   assign rsp_save_now    = rsp_ff.save_now;
   assign rsp_quit_now    = rsp_ff.quit_now;

endmodule

FILE: rtl/srac_checker.sv
// Port-level checker for the lifecycle controller, with its bind
`include "suspend_resume_autosave_controller_assert.svh"

module srac_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_emu_halt,
   input logic rsp_snd_halt,
   input logic rsp_snd_restart,
   input logic rsp_save_now,
   input logic rsp_quit_now
);

   logic [4:0] rsp_flags;
   logic       rsp_stall;
   logic       rsp_others;
   logic       rsp_quit_paused;

   // Shorthand terms for the properties
   assign rsp_flags       = {rsp_emu_halt, rsp_snd_halt, rsp_snd_restart, rsp_save_now,
                             rsp_quit_now};
   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign rsp_others      = rsp_emu_halt || rsp_snd_halt || rsp_save_now || rsp_quit_now;
   assign rsp_quit_paused = rsp_valid && rsp_quit_now && rsp_emu_halt;

   // A stalled result item holds its flags
   `SRAC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_flags), "held item changed")

   // Simulation and audio are always paused together
   `SRAC_ASSERT_NOW(a_pause_pair, rsp_valid, rsp_emu_halt == rsp_snd_halt, "pause flags disagree")

   // A resume item carries nothing else
   `SRAC_ASSERT_NOW(a_resume_alone, rsp_valid && rsp_snd_restart, !rsp_others, "resume not alone")

   // An immediate exit always comes with a save
   `SRAC_ASSERT_NOW(a_exit_saves, rsp_quit_paused, rsp_save_now, "exit without save")

endmodule

bind suspend_resume_autosave_controller srac_checker u_srac_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_emu_halt    (rsp_emu_halt),
   .rsp_snd_halt    (rsp_snd_halt),
   .rsp_snd_restart (rsp_snd_restart),
   .rsp_save_now    (rsp_save_now),
   .rsp_quit_now    (rsp_quit_now)
);

FILE: bench/suspend_resume_autosave_controller_checker.sv
`timescale 1ns / 100ps
// Checker for the lifecycle controller: predicts the request flags of each item and compares
module suspend_resume_autosave_controller_checker
   import srac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [47:0] req_now_us,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_emu_halt,
   input  logic        rsp_snd_halt,
   input  logic        rsp_snd_restart,
   input  logic        rsp_save_now,
   input  logic        rsp_quit_now,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          requests_outstanding,
   output mode_type    model_mode,
   output logic [47:0] model_deadline,
   output logic [31:0] model_period
);

   localparam logic [63:0] TIME_MASK = 64'h0000_FFFF_FFFF_FFFF;
   localparam int DEPTH_LIMIT = 255;

   // predicted controller state
   mode_type    cur_mode;
   logic [63:0] next_deadline;
   logic [31:0] autosave_period;
   int          crit_depth;
   logic        save_held;
   logic        exit_held;

   flags_type   pending_requests[$];
   int          fail_count = 0;

   // saturating timestamp sum
   function automatic logic [63:0] time_sum(input logic [63:0] a, input logic [63:0] b);
      if (b > TIME_MASK - a)
         return TIME_MASK;
      return a + b;
   endfunction

   // first deadline + k*period strictly above now, saturated
   function automatic logic [63:0] catch_up(input logic [63:0] dl, input logic [63:0] now,
                                            input logic [63:0] per);
      logic [63:0] k;
      k = (now - dl) / per + 64'd1;
      if (k > (TIME_MASK - dl) / per)
         return TIME_MASK;
      return dl + k * per;
   endfunction

   // apply one item to the predicted state and work out its flags
   task automatic predict_requests(input logic [3:0] op, input logic [47:0] now_in,
                                   output flags_type f);
      logic [63:0] now;
      logic [63:0] per;
      logic        crit;
      f = '0;
      now = {16'd0, now_in};
      per = {32'd0, autosave_period};
      crit = crit_depth > 0;
      case (op)
         OP_SUSPEND, OP_SLEEP: begin
            if (cur_mode == MODE_RUNNING) begin
               f.emu_halt = 1'b1;
               f.snd_halt = 1'b1;
               if (crit) save_held = 1'b1;
               else f.save_now = 1'b1;
               cur_mode = MODE_SUSPENDED;
            end
         end
         OP_RESTORE, OP_WAKE: begin
            if (cur_mode == MODE_SUSPENDED) begin
               f.snd_restart = 1'b1;
               cur_mode = MODE_RUNNING;
               next_deadline = time_sum(now, per);
            end
         end
         OP_EXIT: begin
            if (cur_mode != MODE_EXIT_PENDING) begin
               cur_mode = MODE_EXIT_PENDING;
               f.emu_halt = 1'b1;
               f.snd_halt = 1'b1;
               if (crit) begin
                  save_held = 1'b1;
                  exit_held = 1'b1;
               end else begin
                  f.save_now = 1'b1;
                  f.quit_now = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (cur_mode == MODE_RUNNING && now >= next_deadline) begin
               if (crit) save_held = 1'b1;
               else f.save_now = 1'b1;
               next_deadline = catch_up(next_deadline, now, per);
            end
            // held requests go out once no section is open
            if (!crit && save_held) begin
               save_held = 1'b0;
               f.save_now = 1'b1;
            end
            if (!crit && exit_held) begin
               exit_held = 1'b0;
               f.quit_now = 1'b1;
            end
         end
         OP_RESET: begin
            cur_mode = MODE_RUNNING;
            next_deadline = time_sum(now, per);
            crit_depth = 0;
            save_held = 1'b0;
            exit_held = 1'b0;
         end
         OP_CRIT_BEGIN: begin
            if (crit_depth < DEPTH_LIMIT) crit_depth++;
         end
         OP_CRIT_END: begin
            if (crit_depth > 0) crit_depth--;
         end
         default: ;
      endcase
   endtask

   task automatic report_field(input string name, input logic want, input logic seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, seen);
         fail_count++;
      end
   endtask

   // watch configuration, input and result channels
   always @(posedge clock) begin : watch
      flags_type f;
      flags_type got;
      if (reset) begin
         cur_mode = MODE_RUNNING;
         autosave_period = MIN_PERIOD_US;
         next_deadline = {32'd0, MIN_PERIOD_US};
         crit_depth = 0;
         save_held = 1'b0;
         exit_held = 1'b0;
         pending_requests.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_PERIOD_ADDR)
            autosave_period = (pwdata < MIN_PERIOD_US) ? MIN_PERIOD_US : pwdata;
         if (req_valid && req_ready) begin
            predict_requests(req_opcode, req_now_us, f);
            pending_requests.push_back(f);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_emu_halt, rsp_snd_halt, rsp_snd_restart,
                   rsp_save_now, rsp_quit_now};
            if (pending_requests.size() == 0) begin
               $display("%0t: result item with nothing expected, actual %b", $time, got);
               fail_count++;
            end else begin
               f = pending_requests.pop_front();
               report_field("emu_halt", f.emu_halt, got.emu_halt);
               report_field("snd_halt", f.snd_halt, got.snd_halt);
               report_field("snd_restart", f.snd_restart, got.snd_restart);
               report_field("save_now", f.save_now, got.save_now);
               report_field("quit_now", f.quit_now, got.quit_now);
            end
         end
      end
      mismatches = fail_count;
      requests_outstanding = pending_requests.size();
      model_mode = cur_mode;
      model_deadline = next_deadline[47:0];
      model_period = autosave_period;
   end

endmodule

FILE: bench/suspend_resume_autosave_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top for the lifecycle controller: stimulus, idling, watchdog and verdict
module suspend_resume_autosave_controller_tb;
   import srac_pkg::*;

   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [3:0]  OP_UNUSED_LO = OP_CRIT_END + 4'd1;
   localparam logic [3:0]  OP_UNUSED_HI = 4'hF;
   localparam int STALL_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_opcode = OP_SUSPEND;
   logic [47:0] req_now_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_emu_halt;
   logic        rsp_snd_halt;
   logic        rsp_snd_restart;
   logic        rsp_save_now;
   logic        rsp_quit_now;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = CSR_PERIOD_ADDR;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic        idle_on = 1'b1;
   logic        stall_request = 1'b0;
   int          quiet_cycles = 0;

   int          mismatches;
   int          requests_outstanding;
   mode_type    model_mode;
   logic [47:0] model_deadline;
   logic [31:0] model_period;
   logic [31:0] period_plan [6];

   suspend_resume_autosave_controller dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_now_us(req_now_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_emu_halt(rsp_emu_halt), .rsp_snd_halt(rsp_snd_halt),
      .rsp_snd_restart(rsp_snd_restart), .rsp_save_now(rsp_save_now),
      .rsp_quit_now(rsp_quit_now),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   suspend_resume_autosave_controller_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_now_us(req_now_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_emu_halt(rsp_emu_halt), .rsp_snd_halt(rsp_snd_halt),
      .rsp_snd_restart(rsp_snd_restart), .rsp_save_now(rsp_save_now),
      .rsp_quit_now(rsp_quit_now),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .requests_outstanding(requests_outstanding),
      .model_mode(model_mode), .model_deadline(model_deadline), .model_period(model_period)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !(idle_on && $urandom_range(0, 99) < 38);
      end
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("suspend_resume_autosave_controller verification failed");
            $finish;
         end
      end
   end

   function automatic logic [47:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic logic [47:0] clip_time(input logic [63:0] t);
      return (t > {16'd0, TIME_MAX}) ? TIME_MAX : t[47:0];
   endfunction

   // random item, mostly well-formed; ticks mostly land near the deadline
   task automatic pick_item(output logic [3:0] op, output logic [47:0] now);
      int          r;
      int          sub;
      logic [63:0] wide;
      logic [63:0] d;
      logic [63:0] p;
      logic [63:0] span;
      r = $urandom_range(0, 99);
      sub = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      d = {16'd0, model_deadline};
      p = {32'd0, model_period};
      now = wide[47:0];
      if (r < 40) op = OP_TICK;
      else if (r < 48) op = 4'($urandom_range(OP_SLEEP, OP_SUSPEND));
      else if (r < 57) op = 4'($urandom_range(OP_WAKE, OP_RESTORE));
      else if (r < 62) op = OP_EXIT;
      else if (r < 70) op = OP_RESET;
      else if (r < 82) op = OP_CRIT_BEGIN;
      else if (r < 94) op = OP_CRIT_END;
      else op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      if (op == OP_TICK) begin
         if (sub < 35) begin
            span = wide % (2 * p + 1);
            now = (d > span) ? clip_time(d - span) : '0;
         end else if (sub < 85) begin
            now = clip_time(d + wide % (6 * p + 1));
         end
      end else if (sub < 30) begin
         now = clip_time(d + wide % (2 * p));
      end
      // keep the catch-up loop short
      if (op == OP_TICK && model_mode == MODE_RUNNING && {16'd0, now} >= d &&
          ({16'd0, now} - d) / p > 7)
         now = clip_time(d + wide % (7 * p));
   endtask

   // offer one item, idling at random first; returns once it is taken
   task automatic send_item(input logic [3:0] op_in, input logic [47:0] now_in,
                            input bit choose);
      logic [3:0]  op;
      logic [47:0] now;
      @(negedge clock);
      op = op_in;
      now = now_in;
      if (choose) pick_item(op, now);
      while (idle_on && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode <= op;
      req_now_us <= now;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering until every expected result is back
   task automatic hold_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (requests_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_PERIOD_ADDR;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      period_plan[0] = 32'd0;
      period_plan[1] = 32'd999_999;
      period_plan[2] = MIN_PERIOD_US;
      period_plan[3] = 32'd1_234_567;
      period_plan[4] = 32'hFFFF_FFFF;
      period_plan[5] = $urandom_range(32'hFFFF_FFFF, MIN_PERIOD_US);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // below the minimum: clamps to one second
      write_period(32'd5);

      // directed: deadlines, deferrals, saturation, ignored and unknown opcodes
      send_item(OP_TICK, 48'd0, 0);
      send_item(OP_TICK, 48'd1_000_000, 0);
      send_item(OP_TICK, 48'd4_500_000, 0);
      send_item(OP_CRIT_BEGIN, TIME_MAX, 0);
      send_item(OP_SUSPEND, 48'd0, 0);
      send_item(OP_SLEEP, TIME_MAX, 0);
      send_item(OP_TICK, TIME_MAX, 0);
      send_item(OP_CRIT_END, 48'd0, 0);
      send_item(OP_CRIT_END, TIME_MAX, 0);
      send_item(OP_TICK, 48'd0, 0);
      send_item(OP_WAKE, TIME_MAX - 48'd10, 0);
      send_item(OP_RESTORE, 48'd0, 0);
      send_item(OP_TICK, TIME_MAX, 0);
      send_item(OP_TICK, TIME_MAX, 0);
      send_item(OP_RESET, TIME_MAX - 48'd1_000_005, 0);
      send_item(OP_TICK, TIME_MAX - 48'd3, 0);
      send_item(OP_CRIT_BEGIN, 48'd0, 0);
      send_item(OP_EXIT, 48'd123, 0);
      send_item(OP_EXIT, 48'd0, 0);
      send_item(OP_SUSPEND, 48'd0, 0);
      send_item(OP_TICK, 48'd0, 0);
      send_item(OP_CRIT_END, 48'd0, 0);
      send_item(OP_TICK, TIME_MAX, 0);
      send_item(OP_UNUSED_LO, TIME_MAX, 0);
      send_item(OP_UNUSED_HI, 48'd0, 0);
      send_item(OP_RESET, 48'd0, 0);
      send_item(OP_SLEEP, 48'd0, 0);
      send_item(OP_RESTORE, 48'd5, 0);
      send_item(OP_TICK, 48'd1_000_005, 0);

      // random phases, one period setting each
      for (int ph = 0; ph < 6; ph++) begin
         hold_until_idle();
         write_period(period_plan[ph]);
         idle_on = (ph != 2);
         if (ph == 1) begin
            // receiver holds off while the sender keeps offering
            stall_request = 1'b1;
            idle_on = 1'b0;
            repeat (12) send_item(OP_SUSPEND, '0, 1);
            idle_on = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) send_item(OP_SUSPEND, '0, 1);
         if (ph == 0) begin
            // run the depth into saturation, with held requests on top
            repeat (258) send_item(OP_CRIT_BEGIN, rand_time(), 0);
            send_item(OP_SUSPEND, rand_time(), 0);
            send_item(OP_TICK, rand_time(), 0);
            send_item(OP_EXIT, rand_time(), 0);
            send_item(OP_TICK, rand_time(), 0);
            repeat (3) send_item(OP_CRIT_END, rand_time(), 0);
            send_item(OP_TICK, rand_time(), 0);
            send_item(OP_RESET, rand_time(), 0);
         end
      end
      idle_on = 1'b1;

      hold_until_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && requests_outstanding == 0)
         $display("suspend_resume_autosave_controller verification clean");
      else
         $display("suspend_resume_autosave_controller verification failed");
      $finish;
   end

endmodule

FILE: suspend_resume_autosave_controller.f
+incdir+rtl
rtl/srac_pkg.sv
rtl/suspend_resume_autosave_controller.sv
rtl/srac_checker.sv
bench/suspend_resume_autosave_controller_checker.sv
bench/suspend_resume_autosave_controller_tb.sv
